// ----- sv/semaphore_bank_with_wait_fifos_top_macros.svh -----
// Assertion macros shared by the semaphore bank RTL.
`ifndef SEMAPHORE_BANK_WITH_WAIT_FIFOS_TOP_MACROS_SVH
`define SEMAPHORE_BANK_WITH_WAIT_FIFOS_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Checked property, disabled while reset is high.
`define SBWF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property, also evaluated during reset.
`define SBWF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBWF_ASSERT(lbl, clk, rst, prop, msg)
`define SBWF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- sv/sbwf_pkg.sv -----
// Types and constants of the semaphore bank.
package sbwf_pkg;

  typedef enum logic [1:0] {
    FN_CREATE  = 2'd0,
    FN_WAIT    = 2'd1,
    FN_SIGNAL  = 2'd2,
    FN_DESTROY = 2'd3
  } func_t;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned SEM_W   = 3;
  localparam int unsigned PID_W   = 8;
  localparam int unsigned START_W = 16;
  localparam int unsigned COUNT_W = 15;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

endpackage

// ----- sv/semaphore_bank_with_wait_fifos_top.sv -----
// Bank of counting semaphores with per-semaphore FIFOs of blocked process ids.
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   func, sem_id, proc_id, start_value
//  m_axis    out  m_axis_tvalid / m_axis_tready   status, caller_blocked,
//                                                 released_valid, released_id, count_after
//  cfg       in   cfg_wen                         init_process_id
//
//  One operation per cycle sustained while m_axis accepts results. A transfer lands in
//  the input register; when it advances, the addressed semaphore's count, pointers and
//  fill are updated and the result register loads, driving m_axis_tvalid.
//  The wait store is one RAM (SEM_COUNT*QUEUE_DEPTH entries) with one write and one
//  registered read per cycle; the released id comes from its read register.
//  Reset clears all semaphores, pointers, fill counts and init_process_id at once;
//  the wait store itself is not cleared (fill counts guard every read).
//  Backpressure on m_axis holds the result and then the input register.
`include "semaphore_bank_with_wait_fifos_top_macros.svh"

module semaphore_bank_with_wait_fifos_top #(
  parameter int unsigned SEM_COUNT   = 5,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // func[1:0], sem_id[4:2], proc_id[12:5],
                                     // start_value[28:13], zero[31:29]
  // stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // status[0], caller_blocked[1], released_valid[2],
                                     // released_id[10:3], count_after[25:11], zero[31:26]
  // config
  input  logic        cfg_wen,
  input  logic [7:0]  cfg_wdata      // init_process_id
);

  localparam int unsigned SIW   = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;
  localparam int unsigned QW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MDEP  = SEM_COUNT * QUEUE_DEPTH;
  localparam int unsigned MAW   = (MDEP > 1) ? $clog2(MDEP) : 1;
  localparam int unsigned CW    = sbwf_pkg::COUNT_W;
  localparam int unsigned PW    = sbwf_pkg::PID_W;

  // configuration
  logic [PW-1:0] init_pid;

  // input register
  logic                          r_vld;
  sbwf_pkg::func_t               r_func;
  logic [sbwf_pkg::SEM_W-1:0]    r_sem;
  logic [PW-1:0]                 r_pid;
  logic [sbwf_pkg::START_W-1:0]  r_start;

  // semaphore state
  logic          present [SEM_COUNT];
  logic [CW-1:0] count   [SEM_COUNT];
  logic [QW-1:0] head    [SEM_COUNT];
  logic [QW-1:0] tail    [SEM_COUNT];
  logic [FW-1:0] fill    [SEM_COUNT];

  // wait store
  logic [PW-1:0] wait_mem [MDEP];
  logic [PW-1:0] rd_q;

  // result register
  logic          o_vld;
  logic          o_status;
  logic          o_blocked;
  logic          o_rel_v;
  logic [CW-1:0] o_count;

  // per-item combinational results
  logic           adv;
  logic           sem_ok;
  logic [SIW-1:0] s_idx;
  logic           cur_present;
  logic [CW-1:0]  cur_count;
  logic [QW-1:0]  cur_head;
  logic [QW-1:0]  cur_tail;
  logic [FW-1:0]  cur_fill;
  logic           present_next;
  logic [CW-1:0]  count_next;
  logic [QW-1:0]  head_next;
  logic [QW-1:0]  tail_next;
  logic [FW-1:0]  fill_next;
  logic           st_wr;
  logic           enq;
  logic           deq;
  logic           res_status;
  logic           res_blocked;
  logic [CW-1:0]  res_count;
  logic [CW-1:0]  cnt_dec;
  logic [CW-1:0]  cnt_inc;
  logic [MAW-1:0] wr_addr;
  logic [MAW-1:0] rd_addr;

  assign adv           = r_vld && (!o_vld || m_axis_tready);
  assign s_axis_tready = !r_vld || adv;
  assign m_axis_tvalid = o_vld;
  assign m_axis_tdata  = {6'b0, o_count, (o_rel_v ? rd_q : {PW{1'b0}}),
                          o_rel_v, o_blocked, o_status};

  always_ff @(posedge clk) begin
    if (rst) begin
      init_pid <= '0;
    end else if (cfg_wen) begin
      init_pid <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      r_vld <= 1'b0;
    end else if (s_axis_tready) begin
      r_vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      r_func  <= sbwf_pkg::func_t'(s_axis_tdata[1:0]);
      r_sem   <= s_axis_tdata[4:2];
      r_pid   <= s_axis_tdata[12:5];
      r_start <= s_axis_tdata[28:13];
    end
  end

  assign sem_ok      = (32'(r_sem) < SEM_COUNT);
  assign s_idx       = r_sem[SIW-1:0];
  assign cur_present = sem_ok ? present[s_idx] : 1'b0;
  assign cur_count   = sem_ok ? count[s_idx]   : '0;
  assign cur_head    = sem_ok ? head[s_idx]    : '0;
  assign cur_tail    = sem_ok ? tail[s_idx]    : '0;
  assign cur_fill    = sem_ok ? fill[s_idx]    : '0;

  assign cnt_dec = (cur_count != '0) ? cur_count - CW'(1) : cur_count;
  assign cnt_inc = (cur_count != sbwf_pkg::COUNT_MAX) ? cur_count + CW'(1) : cur_count;

  // operation decode for the addressed semaphore
  always_comb begin
    present_next = cur_present;
    count_next   = cur_count;
    head_next    = cur_head;
    tail_next    = cur_tail;
    fill_next    = cur_fill;
    st_wr        = 1'b0;
    enq          = 1'b0;
    deq          = 1'b0;
    res_status   = sbwf_pkg::STATUS_FAIL;
    res_blocked  = 1'b0;
    res_count    = '0;
    if (sem_ok) begin
      case (r_func)
        sbwf_pkg::FN_CREATE: begin
          if (!cur_present) begin
            present_next = 1'b1;
            count_next   = r_start[15] ? '0 : r_start[CW-1:0];
            head_next    = '0;
            tail_next    = '0;
            fill_next    = '0;
            st_wr        = 1'b1;
            res_status   = sbwf_pkg::STATUS_OK;
          end
          res_count = count_next;
        end
        sbwf_pkg::FN_WAIT: begin
          if (cur_present) begin
            st_wr      = 1'b1;
            res_status = sbwf_pkg::STATUS_OK;
            count_next = cnt_dec;
            if (cnt_dec == '0 && r_pid != init_pid) begin
              if (cur_fill == FW'(QUEUE_DEPTH)) begin
                res_status = sbwf_pkg::STATUS_FAIL;
              end else begin
                enq         = 1'b1;
                res_blocked = 1'b1;
                tail_next   = (32'(cur_tail) == QUEUE_DEPTH - 1) ? '0 : cur_tail + QW'(1);
                fill_next   = cur_fill + FW'(1);
              end
            end
            res_count = count_next;
          end
        end
        sbwf_pkg::FN_SIGNAL: begin
          if (cur_present) begin
            st_wr      = 1'b1;
            res_status = sbwf_pkg::STATUS_OK;
            count_next = cnt_inc;
            // count is always positive after an increment
            if (cur_fill != '0) begin
              deq       = 1'b1;
              head_next = (32'(cur_head) == QUEUE_DEPTH - 1) ? '0 : cur_head + QW'(1);
              fill_next = cur_fill - FW'(1);
            end
            res_count = count_next;
          end
        end
        sbwf_pkg::FN_DESTROY: begin
          if (cur_present) begin
            st_wr        = 1'b1;
            res_status   = sbwf_pkg::STATUS_OK;
            present_next = 1'b0;
            count_next   = '0;
            head_next    = '0;
            tail_next    = '0;
            fill_next    = '0;
            res_count    = '0;
          end
        end
        default: begin
          res_status = sbwf_pkg::STATUS_FAIL;
        end
      endcase
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SEM_COUNT; i++) begin
        present[i] <= 1'b0;
        count[i]   <= '0;
        head[i]    <= '0;
        tail[i]    <= '0;
        fill[i]    <= '0;
      end
    end else if (adv && st_wr) begin
      present[s_idx] <= present_next;
      count[s_idx]   <= count_next;
      head[s_idx]    <= head_next;
      tail[s_idx]    <= tail_next;
      fill[s_idx]    <= fill_next;
    end
  end

  // wait store: enqueue at tail, dequeue at head
  assign wr_addr = MAW'(s_idx) * MAW'(QUEUE_DEPTH) + MAW'(cur_tail);
  assign rd_addr = MAW'(s_idx) * MAW'(QUEUE_DEPTH) + MAW'(cur_head);

  always_ff @(posedge clk) begin
    if (adv && enq) begin
      wait_mem[wr_addr] <= r_pid;
    end
    if (adv && deq) begin
      rd_q <= wait_mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (adv) begin
      o_vld <= 1'b1;
    end else if (m_axis_tready) begin
      o_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_status  <= res_status;
      o_blocked <= res_blocked;
      o_rel_v   <= deq;
      o_count   <= res_count;
    end
  end

  `SBWF_ASSERT(a_block_excl, clk, rst, (o_vld && o_blocked) |-> (o_status == sbwf_pkg::STATUS_OK && !o_rel_v), "blocked result must be a successful wait without release")
  `SBWF_ASSERT(a_fill_bound, clk, rst, (r_vld && sem_ok) |-> (32'(cur_fill) <= QUEUE_DEPTH), "wait queue fill beyond depth")
  `SBWF_ASSERT(a_adv_result, clk, rst, adv |=> o_vld, "processed item produced no result")
  `SBWF_ASSERT(a_free_ready, clk, rst, !o_vld |-> s_axis_tready, "input stalled with empty result register")
  `SBWF_ASSERT_ALWAYS(a_rst_idle, clk, $past(rst) |-> (!r_vld && !o_vld), "pipeline not empty after reset")

endmodule
